[hdl/cta_pkg.sv]
// ----------------------------------------------------------------------------
// cta_pkg
// Shared widths, request codes, queue entry and back-end state type for the
// cyclic and triggered average block.
// ----------------------------------------------------------------------------
package cta_pkg;

  localparam int COUNT_BITS = 24;
  localparam int SUM_W      = 56;
  localparam int DATA_W     = 32;
  localparam int CLEN_W     = 16;
  localparam int DEN_W      = (COUNT_BITS > CLEN_W) ? COUNT_BITS : CLEN_W;

  // radix-4 restoring divider: two quotient bits per cycle
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_STEPS          = SUM_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_STEPS);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_TRIGGER = 1'b1;

  // one classified item waiting for the divider
  typedef struct packed {
    logic                     avg_en;
    logic                     zero_flag;
    logic                     done;
    logic                     fwd;
    logic signed [SUM_W-1:0]  avg_num;
    logic [COUNT_BITS-1:0]    avg_den;
    logic signed [SUM_W-1:0]  cyc_num;
    logic [CLEN_W-1:0]        cyc_den;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_AVG_START,
    B_AVG_WAIT,
    B_CYC_START,
    B_CYC_WAIT,
    B_OUT
  } back_state_t;

endpackage

[hdl/cyclic_and_triggered_average_top.sv]
// ----------------------------------------------------------------------------
// cyclic_and_triggered_average_top
// Cyclic and triggered averaging of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser[0] is the request kind (0 sample, 1 trigger),
// tdata the sample. Every item gives exactly one result item on m_*.
// cfg_* writes the cycle length; it is always ready and also restarts the
// cycle position. Write it only while the block is idle.
// Samples add into both sums; a trigger answers with the triggered average
// and clears all sums, the count and the position.
// The front takes an item and queues it; the back runs each needed
// division on one shared radix-4 divider: one for a trigger with samples
// or a sample, two for a sample that closes a cycle, none for a trigger
// with no samples. With a ready receiver the back is idle again in the
// cycle after the result is taken and only then takes the next item. The
// divider sets the sustained rate.
// The two-entry job queue keeps taking items while a result waits on a
// stalled receiver; when it fills, s_tready drops. A held result stays
// stable until taken.
// Reset (synchronous, rst high) clears the sums, count, position, cycle
// length and queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cyclic_and_triggered_average_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cta_pkg::DATA_W-1:0]      s_tdata,   // [31:0] sample
  input  logic [0:0]                      s_tuser,   // [0] req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [2*cta_pkg::DATA_W-1:0]    m_tdata,   // [31:0] running_average,
                                                     // [63:32] cyclic_mean
  output logic [2:0]                      m_tuser,   // [0] count_was_zero,
                                                     // [1] cyclic_done,
                                                     // [2] forward_average
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cta_pkg::CLEN_W-1:0]      cfg_data
);
  import cta_pkg::*;

  logic                     q_full, q_empty, q_push, q_pop;
  job_t                     q_in, q_out;
  logic                     div_start, div_done;
  logic signed [SUM_W-1:0]  div_num;
  logic [DEN_W-1:0]         div_den;
  logic signed [DATA_W-1:0] div_quot;

  cta_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  cta_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  cta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quot  (div_quot),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  cta_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

[hdl/cta_front.sv]
// ----------------------------------------------------------------------------
// cta_front
// Accepts items and the cycle length register, keeps the sums, count and
// cycle position, and queues one division job per item.
// ----------------------------------------------------------------------------
module cta_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cta_pkg::DATA_W-1:0]    s_tdata,   // [31:0] sample
  input  logic [0:0]                    s_tuser,   // [0] req_type
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cta_pkg::CLEN_W-1:0]    cfg_data,
  input  logic                          q_full,
  output logic                          q_push,
  output cta_pkg::job_t                 q_data
);
  import cta_pkg::*;

  logic [CLEN_W-1:0]       cycle_length;
  logic signed [SUM_W-1:0] cyclic_sum, cyclic_sum_next;
  logic signed [SUM_W-1:0] triggered_sum, triggered_sum_next;
  logic [COUNT_BITS-1:0]   triggered_count, triggered_count_next;
  logic [CLEN_W-1:0]       cyclic_position, cyclic_position_next;
  logic                    accept;
  logic [CLEN_W-1:0]       pos_inc;

  function automatic logic signed [SUM_W-1:0] add_sat(
    input logic signed [SUM_W-1:0]  acc,
    input logic signed [DATA_W-1:0] v
  );
    logic [SUM_W:0] r;
    begin
      r = {acc[SUM_W-1], acc} + {{(SUM_W+1-DATA_W){v[DATA_W-1]}}, v};
      if (r[SUM_W] != r[SUM_W-1]) begin
        return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return r[SUM_W-1:0];
    end
  endfunction

  assign s_tready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign q_push    = accept;
  assign pos_inc   = cyclic_position + CLEN_W'(1);

  always_comb begin
    cyclic_sum_next      = cyclic_sum;
    triggered_sum_next   = triggered_sum;
    triggered_count_next = triggered_count;
    cyclic_position_next = cyclic_position;
    q_data               = '0;
    q_data.cyc_den       = cycle_length;
    if (s_tuser[0] == REQ_TRIGGER) begin
      q_data.zero_flag     = (triggered_count == '0);
      q_data.avg_en        = (triggered_count != '0);
      q_data.avg_num       = triggered_sum;
      q_data.avg_den       = triggered_count;
      q_data.fwd           = (cycle_length == '0);
      cyclic_sum_next      = '0;
      triggered_sum_next   = '0;
      triggered_count_next = '0;
      cyclic_position_next = '0;
    end else begin
      cyclic_sum_next    = add_sat(cyclic_sum, s_tdata);
      triggered_sum_next = add_sat(triggered_sum, s_tdata);
      if (triggered_count != '1) begin
        triggered_count_next = triggered_count + COUNT_BITS'(1);
      end
      q_data.avg_en  = 1'b1;
      q_data.avg_num = triggered_sum_next;
      q_data.avg_den = triggered_count_next;
      if (cycle_length != '0) begin
        cyclic_position_next = pos_inc;
        if (pos_inc >= cycle_length) begin
          q_data.done          = 1'b1;
          q_data.cyc_num       = cyclic_sum_next;
          cyclic_position_next = '0;
          cyclic_sum_next      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_length    <= '0;
      cyclic_sum      <= '0;
      triggered_sum   <= '0;
      triggered_count <= '0;
      cyclic_position <= '0;
    end else begin
      if (accept) begin
        cyclic_sum      <= cyclic_sum_next;
        triggered_sum   <= triggered_sum_next;
        triggered_count <= triggered_count_next;
        cyclic_position <= cyclic_position_next;
      end
      // register write restarts the cycle position
      if (cfg_valid) begin
        cycle_length    <= cfg_data;
        cyclic_position <= '0;
      end
    end
  end

endmodule

[hdl/cta_fifo.sv]
// ----------------------------------------------------------------------------
// cta_fifo
// Short job queue between the front and the back; parts their stalls.
// ----------------------------------------------------------------------------
module cta_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cta_pkg::job_t  push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output cta_pkg::job_t  pop_data
);
  import cta_pkg::*;

  job_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_W:0]   count;
  logic                  do_push, do_pop;

  assign full     = (count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (FIFO_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (FIFO_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/cta_div.sv]
// ----------------------------------------------------------------------------
// cta_div
// Serial signed divider, 56-bit dividend by positive divisor, two quotient
// bits per cycle, quotient truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module cta_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [cta_pkg::SUM_W-1:0]  num,
  input  logic [cta_pkg::DEN_W-1:0]         den,
  output logic                              done,
  output logic signed [cta_pkg::DATA_W-1:0] quot
);
  import cta_pkg::*;

  localparam logic [SUM_W-1:0] POS_LIM = SUM_W'(64'h7FFF_FFFF);
  localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(64'h8000_0000);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-1:0]     rem, rem_next;
  logic [SUM_W-1:0]     qsh, qsh_next;
  logic [DEN_W-1:0]     dsr;
  logic                 neg;
  logic [SUM_W-1:0]     num_u, mag;

  assign num_u = num;
  assign mag   = num_u[SUM_W-1] ? (~num_u + SUM_W'(1)) : num_u;

  always_comb begin
    logic [DEN_W:0]   r_sh;
    logic [DEN_W-1:0] r;
    logic [SUM_W-1:0] q;
    r    = rem;
    q    = qsh;
    r_sh = '0;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      r_sh = {r, q[SUM_W-1]};
      q    = {q[SUM_W-2:0], 1'b0};
      if (r_sh >= {1'b0, dsr}) begin
        r_sh = r_sh - {1'b0, dsr};
        q[0] = 1'b1;
      end
      r = r_sh[DEN_W-1:0];
    end
    rem_next = r;
    qsh_next = q;
  end

  // qsh holds the quotient magnitude once done is high
  always_comb begin
    if (neg) begin
      quot = (qsh > NEG_LIM) ? DATA_W'(32'h8000_0000) : DATA_W'(~qsh[DATA_W-1:0] + 1'b1);
    end else begin
      quot = (qsh > POS_LIM) ? DATA_W'(32'h7FFF_FFFF) : qsh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num_u[SUM_W-1];
      qsh <= mag;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      rem <= rem_next;
      qsh <= qsh_next;
    end
  end

endmodule

[hdl/cta_back.sv]
// ----------------------------------------------------------------------------
// cta_back
// Takes queued jobs, runs up to two divisions on the shared divider and
// holds the result item until the receiver takes it.
// ----------------------------------------------------------------------------
module cta_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  cta_pkg::job_t                     q_data,
  output logic                              q_pop,
  output logic                              div_start,
  output logic signed [cta_pkg::SUM_W-1:0]  div_num,
  output logic [cta_pkg::DEN_W-1:0]         div_den,
  input  logic                              div_done,
  input  logic signed [cta_pkg::DATA_W-1:0] div_quot,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [2*cta_pkg::DATA_W-1:0]      m_tdata,
  output logic [2:0]                        m_tuser
);
  import cta_pkg::*;

  back_state_t              state, state_next;
  job_t                     job;
  logic signed [DATA_W-1:0] avg_q, mean_q;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_data.avg_en) begin
            state_next = B_AVG_START;
          end else if (q_data.done) begin
            state_next = B_CYC_START;
          end else begin
            state_next = B_OUT;
          end
        end
      end
      B_AVG_START: state_next = B_AVG_WAIT;
      B_AVG_WAIT: begin
        if (div_done) begin
          state_next = job.done ? B_CYC_START : B_OUT;
        end
      end
      B_CYC_START: state_next = B_CYC_WAIT;
      B_CYC_WAIT: begin
        if (div_done) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (m_tready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == B_IDLE) && !q_empty;
    div_start = (state == B_AVG_START) || (state == B_CYC_START);
    m_tvalid  = (state == B_OUT);
    if (state == B_CYC_START) begin
      div_num = job.cyc_num;
      div_den = DEN_W'(job.cyc_den);
    end else begin
      div_num = job.avg_num;
      div_den = DEN_W'(job.avg_den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job    <= q_data;
      avg_q  <= '0;
      mean_q <= '0;
    end
    if ((state == B_AVG_WAIT) && div_done) begin
      avg_q <= div_quot;
    end
    if ((state == B_CYC_WAIT) && div_done) begin
      mean_q <= div_quot;
    end
  end

  assign m_tdata = {mean_q, avg_q};
  assign m_tuser = {job.fwd, job.done, job.zero_flag};

endmodule

[hdl/cta_checker.sv]
// ----------------------------------------------------------------------------
// cta_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cta_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [2*cta_pkg::DATA_W-1:0] m_tdata,
  input logic [2:0]                   m_tuser
);
  import cta_pkg::*;

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_mean_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[2*DATA_W-1:DATA_W] == '0)
    else $error("cyclic mean nonzero without cyclic done");

  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[DATA_W-1:0] == '0 && !m_tuser[1])
    else $error("zero-count result carries an average or cyclic flag");

  // forwarding only on triggers, cyclic completion only on samples
  a_fwd_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> !m_tuser[1])
    else $error("forward and cyclic done together");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind cyclic_and_triggered_average_top cta_checker u_cta_checker (.*);
